// ===== sv/lrgd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrgd_pkg
// Shared constants and helpers of the gradient descent trainer.
// ----------------------------------------------------------------------------
package lrgd_pkg;

  localparam int unsigned MaxSamplesDef  = 256;
  localparam int unsigned MaxFeaturesDef = 16;
  localparam int unsigned FracBitsDef    = 16;
  localparam int unsigned LrFrac         = 16;

  localparam logic [1:0] ActLoadFeat = 2'd0;
  localparam logic [1:0] ActLoadTgt  = 2'd1;
  localparam logic [1:0] ActTrain    = 2'd2;
  localparam logic [1:0] ActPredict  = 2'd3;

  localparam logic [1:0] KindPred  = 2'd0;
  localparam logic [1:0] KindCoef  = 2'd1;
  localparam logic [1:0] KindError = 2'd2;

  localparam logic [1:0] RegLr     = 2'd0;
  localparam logic [1:0] RegEpochs = 2'd1;
  localparam logic [1:0] RegBias   = 2'd2;
  localparam logic [1:0] RegNfeat  = 2'd3;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) r = 32'sh7fffffff;
    else if (x < -66'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/lrgd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrgd_ram
// Generic single port RAM with registered read.
// ----------------------------------------------------------------------------
module lrgd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire  [$clog2(Depth)-1:0]  addr_i,
  input  wire  [Width-1:0]          wdata_i,
  output logic [Width-1:0]          rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ===== sv/lrgd_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrgd_divider
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module lrgd_divider (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  wire  signed [63:0] num_i,
  input  wire         [16:0] den_i,
  output logic               done_o,
  output logic signed [63:0] quot_o
);
  logic [63:0] quo_q, quo_d;
  logic [16:0] den_q;
  logic        neg_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [17:0] part;
  logic [16:0] acc_q, acc_d;

  // acc holds the partial remainder while quo shifts in bits
  always_comb begin
    part  = {acc_q, quo_q[63]};
    quo_d = {quo_q[62:0], 1'b0};
    if (part >= {1'b0, den_q}) begin
      acc_d    = 17'(part - {1'b0, den_q});
      quo_d[0] = 1'b1;
    end else begin
      acc_d = part[16:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= busy_q && !start_i && (cnt_q == 7'd1);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
        neg_q  <= num_i[63];
        quo_q  <= num_i[63] ? 64'(-num_i) : 64'(num_i);
        acc_q  <= '0;
        den_q  <= den_i;
      end else if (busy_q) begin
        quo_q <= quo_d;
        acc_q <= acc_d;
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) busy_q <= 1'b0;
      end
    end
  end

  assign quot_o = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule
`default_nettype wire

// ===== sv/linear_regression_gd_trainer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linear_regression_gd_trainer
// Batch gradient descent trainer for linear regression, Q16.16 values.
// ----------------------------------------------------------------------------
// Any item (load, predict or train) is taken only while the block is idle and
// its result register is empty or being read. A train item runs a sequencer
// over one shared multiplier and one serial divider, and the block is not ready
// until the last coefficient, or an error item, sits in the result register.
// With F = num_features, N samples and E epochs, each epoch has a setup step;
// then, for each sample, a store read and a multiply per feature for the
// estimate, an error step, and a read and a multiply per feature for the
// gradient; then a divider start, a serial divide and a step for each of the F
// weights and the bias. The F+1 results then stream out, one per cycle when
// taken.
// No clearing pass is needed after reset.
module linear_regression_gd_trainer #(
  parameter int unsigned MaxSamples  = lrgd_pkg::MaxSamplesDef,
  parameter int unsigned MaxFeatures = lrgd_pkg::MaxFeaturesDef,
  parameter int unsigned FracBits    = lrgd_pkg::FracBitsDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [55:0] s_axis_tdata,  // action, row, column, value, sample_count
  input  wire         s_axis_tlast,  // row_done
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,  // result_value
  output logic [1:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast,  // last
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [23:0] cfg_data_i
);
  import lrgd_pkg::*;

  localparam int unsigned SW = (MaxSamples > 1) ? $clog2(MaxSamples) : 1;
  localparam int unsigned FW = (MaxFeatures > 1) ? $clog2(MaxFeatures) : 1;
  localparam int unsigned AW = SW + FW;

  typedef enum logic [3:0] {
    StIdle, StEpoch, StFetch, StMacW, StErr, StMacG, StNextS, StDiv, StDivWait,
    StOut, StErrOut
  } state_e;

  state_e state_q;

  logic [1:0]  act;
  logic [7:0]  in_row;
  logic [3:0]  in_col;
  logic signed [31:0] in_val;
  logic [8:0]  in_cnt;
  assign act    = s_axis_tdata[1:0];
  assign in_row = s_axis_tdata[9:2];
  assign in_col = s_axis_tdata[13:10];
  assign in_val = s_axis_tdata[45:14];
  assign in_cnt = s_axis_tdata[54:46];

  logic [23:0] lr_q;
  logic [15:0] epochs_q;
  logic        ub_q;
  logic [4:0]  nf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= 24'd655; epochs_q <= 16'd1000; ub_q <= 1'b1; nf_q <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegLr:     lr_q <= cfg_data_i;
        RegEpochs: epochs_q <= cfg_data_i[15:0];
        RegBias:   ub_q <= cfg_data_i[0];
        RegNfeat:  nf_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] w_q [MaxFeatures];
  logic signed [31:0] b_q;
  logic signed [63:0] g_q [MaxFeatures];
  logic signed [63:0] bg_q;
  logic signed [63:0] pacc_q;
  logic [7:0]  pcnt_q;
  logic        pbad_q;

  logic [16:0] n_q;
  logic [15:0] ep_q;
  logic [SW:0] smp_q;
  logic [FW:0] j_q;
  logic signed [65:0] yh_q;
  logic signed [31:0] err_q;

  // stores
  logic          f_we, t_we;
  logic [AW-1:0] f_addr;
  logic [SW-1:0] t_addr;
  logic [31:0]   f_rd, t_rd;
  logic          ld_f, ld_t, acc_in;

  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign ld_f = acc_in && act == ActLoadFeat && 32'(in_row) < MaxSamples
                && 32'(in_col) < MaxFeatures;
  assign ld_t = acc_in && act == ActLoadTgt && 32'(in_row) < MaxSamples;
  assign f_we = ld_f;
  assign t_we = ld_t;
  assign f_addr = ld_f ? {SW'(in_row), FW'(in_col)} : {smp_q[SW-1:0], j_q[FW-1:0]};
  assign t_addr = ld_t ? SW'(in_row) : smp_q[SW-1:0];

  lrgd_ram #(.Width(32), .Depth(1 << AW)) u_feat (
    .clk_i, .we_i(f_we), .addr_i(f_addr), .wdata_i(in_val), .rdata_o(f_rd));
  lrgd_ram #(.Width(32), .Depth(1 << SW)) u_tgt (
    .clk_i, .we_i(t_we), .addr_i(t_addr), .wdata_i(in_val), .rdata_o(t_rd));

  // shared multiplier
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;
  logic signed [63:0] prod_sh;
  assign prod    = mul_a * mul_b;
  assign prod_sh = prod >>> FracBits;

  // divider
  logic               div_start, div_done;
  logic signed [63:0] div_num, div_q;
  lrgd_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(n_q),
    .done_o(div_done), .quot_o(div_q));

  logic signed [31:0] coef;
  logic signed [31:0] avg;
  logic signed [56:0] stp;
  logic signed [31:0] neww;
  logic [FW:0] nf_ext;
  assign nf_ext = (FW+1)'(nf_q);

  always_comb begin
    mul_a   = 32'sd0;
    mul_b   = $signed(f_rd);
    if (state_q == StMacW) mul_a = (j_q < nf_ext) ? w_q[j_q[FW-1:0]] : 32'sd0;
    else if (state_q == StMacG) mul_a = err_q;
    else if (state_q == StIdle) begin
      mul_a = w_q[in_col[FW-1:0] & FW'(MaxFeatures-1)];
      mul_b = in_val;
    end
    coef    = (j_q < nf_ext) ? w_q[j_q[FW-1:0]] : b_q;
    div_num = (j_q < nf_ext) ? g_q[j_q[FW-1:0]] : bg_q;
    avg     = sat32(66'(div_q));
    stp     = ($signed({1'b0, lr_q}) * avg) >>> LrFrac;
    neww    = sat32(66'(coef) - 66'(stp));
  end
  assign div_start = (state_q == StDiv);

  logic pcol_ok;
  assign pcol_ok = in_col < nf_q && 32'(in_col) < MaxFeatures;

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata <= '0; m_axis_tuser <= '0; m_axis_tlast <= 1'b0;
      for (int k = 0; k < MaxFeatures; k++) begin
        w_q[k] <= '0; g_q[k] <= '0;
      end
      b_q <= '0; bg_q <= '0; pacc_q <= '0; pcnt_q <= '0; pbad_q <= 1'b0;
      n_q <= '0; ep_q <= '0; smp_q <= '0; j_q <= '0; yh_q <= '0; err_q <= '0;
    end else begin
      logic out_set;
      out_set = 1'b0;
      case (state_q)
        StIdle: begin
          if (acc_in && act == ActTrain) begin
            if (in_cnt == 9'd0 || 32'(in_cnt) > MaxSamples || nf_q == 5'd0
                || 32'(nf_q) > MaxFeatures) begin
              state_q <= StErrOut;
            end else begin
              for (int k = 0; k < MaxFeatures; k++) w_q[k] <= '0;
              b_q <= '0;
              n_q <= 17'(in_cnt);
              ep_q <= epochs_q;
              state_q <= StEpoch;
            end
          end else if (acc_in && act == ActPredict) begin
            logic signed [63:0] pn;
            pn = pacc_q + (pcol_ok ? prod_sh : 64'sd0);
            if (s_axis_tlast) begin
              out_set = 1'b1;
              m_axis_tlast <= 1'b1;
              if (!pcol_ok || pbad_q ||
                  ((pcnt_q != 8'd255 ? pcnt_q + 8'd1 : pcnt_q) != 8'(nf_q))) begin
                m_axis_tuser <= KindError; m_axis_tdata <= '0;
              end else begin
                m_axis_tuser <= KindPred;
                m_axis_tdata <= sat32(66'(pn) + (ub_q ? 66'(b_q) : 66'sd0));
              end
              pacc_q <= '0; pcnt_q <= '0; pbad_q <= 1'b0;
            end else begin
              if (!pcol_ok) pbad_q <= 1'b1;
              if (pcnt_q != 8'd255) pcnt_q <= pcnt_q + 8'd1;
              pacc_q <= pn;
            end
          end
        end
        StErrOut: begin
          if (out_free) begin
            out_set = 1'b1; m_axis_tuser <= KindError;
            m_axis_tdata <= '0; m_axis_tlast <= 1'b1;
            state_q <= StIdle;
          end
        end
        StEpoch: begin
          if (ep_q == 16'd0) begin
            j_q <= '0; state_q <= StOut;
          end else begin
            ep_q <= ep_q - 16'd1;
            for (int k = 0; k < MaxFeatures; k++) g_q[k] <= '0;
            bg_q <= '0; smp_q <= '0; j_q <= '0; yh_q <= '0;
            state_q <= StFetch;
          end
        end
        StFetch: begin
          // address is settled, read data next cycle
          state_q <= StMacW;
        end
        StMacW: begin
          yh_q <= yh_q + 66'(prod_sh);
          if (j_q + 1'b1 == nf_ext) begin
            state_q <= StErr;
          end else begin
            j_q <= j_q + 1'b1; state_q <= StFetch;
          end
        end
        StErr: begin
          logic signed [31:0] yh;
          logic signed [31:0] e;
          yh = sat32(yh_q + (ub_q ? 66'(b_q) : 66'sd0));
          e  = sat32(66'(yh) - 66'($signed(t_rd)));
          err_q <= e;
          if (ub_q) bg_q <= bg_q + 64'(e);
          j_q <= '0;
          state_q <= StNextS;
        end
        StNextS: begin
          // feature read for gradient phase
          state_q <= StMacG;
        end
        StMacG: begin
          g_q[j_q[FW-1:0]] <= g_q[j_q[FW-1:0]] + prod_sh;
          if (j_q + 1'b1 == nf_ext) begin
            j_q <= '0; yh_q <= '0;
            if (smp_q + 1'b1 == (SW+1)'(n_q)) begin
              state_q <= StDiv;
            end else begin
              smp_q <= smp_q + 1'b1; state_q <= StFetch;
            end
          end else begin
            j_q <= j_q + 1'b1; state_q <= StNextS;
          end
        end
        StDiv: state_q <= StDivWait;
        StDivWait: begin
          if (div_done) begin
            if (j_q < nf_ext) w_q[j_q[FW-1:0]] <= neww;
            else if (ub_q) b_q <= neww;
            if (j_q == nf_ext) state_q <= StEpoch;
            else begin
              j_q <= j_q + 1'b1; state_q <= StDiv;
            end
          end
        end
        StOut: begin
          if (out_free) begin
            out_set = 1'b1; m_axis_tuser <= KindCoef;
            m_axis_tdata  <= coef;
            m_axis_tlast  <= (j_q == nf_ext);
            if (j_q == nf_ext) state_q <= StIdle;
            else j_q <= j_q + 1'b1;
          end
        end
        default: state_q <= StIdle;
      endcase
      if (out_set) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  assign s_axis_tready = (state_q == StIdle) && out_free;
endmodule
`default_nettype wire

// ===== sim/lrgd_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lrgd_result_checker
// Watches the input, output and register ports of the trainer, predicts every
// result from its own copy of the sample store, weights and registers, and
// compares each output item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lrgd_result_checker (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid,
  input  wire        s_axis_tready,
  input  wire [55:0] s_axis_tdata,
  input  wire        s_axis_tlast,
  input  wire        m_axis_tvalid,
  input  wire        m_axis_tready,
  input  wire [31:0] m_axis_tdata,
  input  wire [1:0]  m_axis_tuser,
  input  wire        m_axis_tlast,
  input  wire        cfg_we_i,
  input  wire [1:0]  cfg_idx_i,
  input  wire [23:0] cfg_data_i,
  output int         errors_o,
  output int         pending_o
);
  import lrgd_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic        last;
  } coef_item_t;

  coef_item_t expected_results[$];

  logic signed [31:0] feat_mem [4096];
  logic signed [31:0] tgt_mem  [256];
  logic signed [31:0] weights  [16];
  logic signed [31:0] bias_val;
  longint             pred_sum;
  int                 pred_feats;
  bit                 pred_bad;

  logic [23:0] lr_q;
  logic [15:0] epochs_q;
  logic        bias_on_q;
  logic [4:0]  nfeat_q;

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint descend(longint w, longint acc, longint n);
    longint avg;
    longint step;
    avg  = clamp32(acc / n);
    step = (longint'({40'd0, lr_q}) * avg) >>> LrFrac;
    return clamp32(w - step);
  endfunction

  task automatic push_result(logic [1:0] kind, longint v, logic last);
    coef_item_t it;
    it.kind  = kind;
    it.value = v[31:0];
    it.last  = last;
    expected_results = {expected_results, it};
  endtask

  task automatic run_training(int n);
    longint gacc [16];
    longint bacc;
    longint yhat;
    longint err;
    int     d;
    d = nfeat_q;
    if (n == 0 || n > 256 || d == 0 || d > 16) begin
      push_result(KindError, 0, 1'b1);
    end else begin
      for (int j = 0; j < 16; j++) weights[j] = '0;
      bias_val = '0;
      for (int e = 0; e < epochs_q; e++) begin
        for (int j = 0; j < 16; j++) gacc[j] = 0;
        bacc = 0;
        for (int i = 0; i < n; i++) begin
          yhat = 0;
          for (int j = 0; j < d; j++)
            yhat += (longint'(weights[j]) * longint'(feat_mem[i*16+j])) >>> FracBitsDef;
          if (bias_on_q) yhat += longint'(bias_val);
          yhat = clamp32(yhat);
          err  = clamp32(yhat - longint'(tgt_mem[i]));
          for (int j = 0; j < d; j++)
            gacc[j] += (err * longint'(feat_mem[i*16+j])) >>> FracBitsDef;
          if (bias_on_q) bacc += err;
        end
        for (int j = 0; j < d; j++) begin
          weights[j] = descend(longint'(weights[j]), gacc[j], n);
        end
        if (bias_on_q) bias_val = descend(longint'(bias_val), bacc, n);
      end
      for (int j = 0; j < d; j++) push_result(KindCoef, longint'(weights[j]), 1'b0);
      push_result(KindCoef, longint'(bias_val), 1'b1);
    end
  endtask

  task automatic absorb_item(logic [55:0] d, logic row_done);
    logic [1:0]         act;
    logic [7:0]         row;
    logic [3:0]         col;
    logic signed [31:0] val;
    logic [8:0]         cnt;
    longint             r;
    act = d[1:0];
    row = d[9:2];
    col = d[13:10];
    val = d[45:14];
    cnt = d[54:46];
    case (act)
      ActLoadFeat: feat_mem[{row, col}] = val;
      ActLoadTgt:  tgt_mem[row] = val;
      ActTrain:    run_training(int'(cnt));
      default: begin
        if (col < nfeat_q) pred_sum += (longint'(weights[col]) * longint'(val)) >>> FracBitsDef;
        else pred_bad = 1'b1;
        if (pred_feats < 255) pred_feats++;
        if (row_done) begin
          if (pred_bad || pred_feats != nfeat_q) begin
            push_result(KindError, 0, 1'b1);
          end else begin
            r = pred_sum;
            if (bias_on_q) r += longint'(bias_val);
            push_result(KindPred, clamp32(r), 1'b1);
          end
          pred_sum   = 0;
          pred_feats = 0;
          pred_bad   = 1'b0;
        end
      end
    endcase
  endtask

  initial begin
    errors_o   = 0;
    pending_o  = 0;
    for (int j = 0; j < 16; j++) weights[j] = '0;
    bias_val   = '0;
    pred_sum   = 0;
    pred_feats = 0;
    pred_bad   = 1'b0;
    lr_q       = 24'd655;
    epochs_q   = 16'd1000;
    bias_on_q  = 1'b1;
    nfeat_q    = 5'd16;
  end

  always @(posedge clk_i) begin
    coef_item_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegLr:     lr_q      = cfg_data_i;
          RegEpochs: epochs_q  = cfg_data_i[15:0];
          RegBias:   bias_on_q = cfg_data_i[0];
          RegNfeat:  nfeat_q   = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) absorb_item(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result kind %0d value %h last %0d", $time,
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
          errors_o++;
        end else begin
          want = expected_results.pop_front();
          if (want.kind !== m_axis_tuser) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, m_axis_tuser);
            errors_o++;
          end
          if (want.value !== m_axis_tdata) begin
            $display("%0t: value expected %h actual %h", $time, want.value, m_axis_tdata);
            errors_o++;
          end
          if (want.last !== m_axis_tlast) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, m_axis_tlast);
            errors_o++;
          end
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// ===== sim/linear_regression_gd_trainer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_regression_gd_trainer_tb
// Drives loads, trains and predict rows into the trainer under random stalls
// on both sides, across several register settings, and reports the verdict.
// ----------------------------------------------------------------------------
module linear_regression_gd_trainer_tb;
  import lrgd_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  wire         s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic        s_axis_tlast;
  wire         m_axis_tvalid;
  logic        m_axis_tready;
  wire  [31:0] m_axis_tdata;
  wire  [1:0]  m_axis_tuser;
  wire         m_axis_tlast;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [23:0] cfg_data_i;
  int          errors;
  int          pending;

  int  items_sent  = 0;
  int  trains_sent = 0;
  int  rows_sent   = 0;
  int  phases      = 0;
  bit  quiet       = 1'b0;
  bit  hold_req    = 1'b0;
  bit  hold_done   = 1'b0;
  int  cur_nfeat;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  linear_regression_gd_trainer uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  lrgd_result_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    #6_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("[linear_regression_gd_trainer] ERROR");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request, none at the end
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  function automatic logic [55:0] pack_item(logic [1:0] act, logic [7:0] row, logic [3:0] col,
                                            logic [31:0] val, logic [8:0] cnt);
    return {1'b0, cnt, val, col, row, act};
  endfunction

  function automatic logic [31:0] rand_value();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($urandom_range(0, 32'h80000)) - 32'h40000;  // about +-4.0
  endfunction

  // called at a rising edge; leaves valid high for a following item
  task automatic send(logic [55:0] d, logic lst);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= lst;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic configure(logic [23:0] lr, logic [15:0] ep, logic ub, logic [4:0] nf);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegLr;
    cfg_data_i <= lr;
    @(posedge clk_i);
    cfg_idx_i  <= RegEpochs;
    cfg_data_i <= {8'd0, ep};
    @(posedge clk_i);
    cfg_idx_i  <= RegBias;
    cfg_data_i <= {23'd0, ub};
    @(posedge clk_i);
    cfg_idx_i  <= RegNfeat;
    cfg_data_i <= {19'd0, nf};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_data_i <= 24'($urandom);
    @(posedge clk_i);
    cur_nfeat = nf;
  endtask

  task automatic train(logic [8:0] cnt);
    send(pack_item(ActTrain, 8'($urandom), 4'($urandom), $urandom, cnt),
         1'($urandom_range(0, 1)));
    trains_sent++;
  endtask

  // loads rows 0..n-1 (d features and a target each), then trains on them
  task automatic training_set(int n, int d);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < d; j++)
        send(pack_item(ActLoadFeat, 8'(i), 4'(j), rand_value(), 9'($urandom)),
             1'($urandom_range(0, 1)));
      send(pack_item(ActLoadTgt, 8'(i), 4'($urandom), rand_value(), 9'($urandom)),
           1'($urandom_range(0, 1)));
    end
    train(9'(n));
  endtask

  task automatic predict_row(int nf);
    int cols [16];
    int k;
    int t;
    for (int j = 0; j < 16; j++) cols[j] = j;
    for (int j = nf - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      t = cols[j]; cols[j] = cols[k]; cols[k] = t;
    end
    for (int j = 0; j < nf; j++)
      send(pack_item(ActPredict, 8'($urandom), 4'(cols[j]), rand_value(), 9'($urandom)),
           j == nf - 1);
    rows_sent++;
  endtask

  task automatic broken_row();
    int n;
    n = $urandom_range(1, 5);
    for (int j = 0; j < n; j++)
      send(pack_item(ActPredict, 8'($urandom), 4'($urandom), $urandom, 9'($urandom)),
           j == n - 1);
    rows_sent++;
  endtask

  task automatic random_config();
    logic [23:0] lr;
    logic [4:0]  nf;
    case ($urandom_range(0, 4))
      0: lr = 24'd0;
      1: lr = 24'hffffff;
      2: lr = 24'd655;
      3: lr = 24'($urandom);
      default: lr = 24'($urandom_range(0, 65536));
    endcase
    case ($urandom_range(0, 9))
      0: nf = 5'd0;
      1: nf = 5'($urandom_range(17, 31));
      2, 3: nf = 5'($urandom_range(1, 16));
      default: nf = 5'($urandom_range(1, 4));
    endcase
    configure(lr, 16'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), nf);
  endtask

  initial begin
    int d;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= RegLr;
    cfg_data_i    <= '0;
    cur_nfeat     = 16;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: huge epoch count and bad feature count, then zero epochs
    configure(24'hffffff, 16'hffff, 1'b1, 5'd0);
    train(9'd5);
    predict_row(1);
    wait_idle();
    configure(24'hffffff, 16'd0, 1'b1, 5'd16);
    train(9'd256);
    train(9'd0);
    train(9'd511);
    send(pack_item(ActPredict, 8'hff, 4'hf, 32'h7fffffff, 9'h1ff), 1'b0);
    send(pack_item(ActPredict, 8'h00, 4'h0, 32'h80000000, 9'h000), 1'b1);
    send(pack_item(ActLoadFeat, 8'hff, 4'hf, 32'h80000000, 9'h1ff), 1'b1);
    send(pack_item(ActLoadTgt, 8'hff, 4'h0, 32'h7fffffff, 9'h000), 1'b0);
    wait_idle();
    configure(24'd655, 16'd2, 1'b0, 5'd2);
    training_set(2, 2);
    predict_row(2);
    wait_idle();

    // output held off for a long stretch while predict rows keep coming
    configure(24'd40000, 16'd1, 1'b1, 5'd1);
    hold_req = 1'b1;
    for (int k = 0; k < 40; k++)
      send(pack_item(ActPredict, 8'($urandom), 4'd0, rand_value(), 9'($urandom)), 1'b1);
    wait_idle();

    while (items_sent < 440) begin
      random_config();
      phases++;
      for (int s = 0; s < 6 && items_sent < 450; s++) begin
        if (items_sent > 380) quiet = 1'b1;
        d = (cur_nfeat >= 1 && cur_nfeat <= 16) ? cur_nfeat : $urandom_range(1, 4);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: training_set($urandom_range(1, 6), d);
          4, 5, 6: begin
            if (cur_nfeat >= 1 && cur_nfeat <= 16) predict_row(cur_nfeat);
            else broken_row();
          end
          7: broken_row();
          8: train(($urandom_range(0, 1) == 0) ? 9'd0 : 9'($urandom_range(257, 511)));
          default: begin
            repeat (3)
              send(pack_item(2'($urandom_range(0, 1)), 8'($urandom), 4'($urandom),
                             $urandom, 9'($urandom)),
                   1'($urandom_range(0, 1)));
          end
        endcase
      end
      wait_idle();
    end

    repeat (100) @(posedge clk_i);
    $display("%0d items sent over %0d random settings: %0d trains, %0d predict rows",
             items_sent, phases, trains_sent, rows_sent);
    $display("covered bad counts, zero and maximum rates, bias on and off, one long output stall");
    if (errors == 0) begin
      $display("[linear_regression_gd_trainer] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[linear_regression_gd_trainer] ERROR");
    end
    $finish;
  end

endmodule
